### sv/afu_pkg.sv
// Package for the activation function unit: widths, codes, types and table builder.
`timescale 1ns / 1ps

package afu_pkg;

   localparam int DATA_WIDTH    = 16;
   localparam int FRAC_BITS     = 12;
   localparam int TABLE_ENTRIES = 256;

   localparam int SPAN_LOG2 = 3;                      // tables span |x| in [0, 8]
   localparam int SH        = FRAC_BITS + SPAN_LOG2;  // fraction bits of the table position
   localparam int MAG_W     = DATA_WIDTH;             // |x| including the most negative code
   localparam int IDX_W     = $clog2(TABLE_ENTRIES + 1);
   localparam int TW        = FRAC_BITS + 1;          // table entries reach 1.0
   localparam int PW        = MAG_W + IDX_W + SH;     // position product, always wider than SH

   localparam int SLOPE_W   = 16;
   localparam int SCALE_W   = 15;
   localparam int ELU_FRAC  = 12;
   localparam int EW        = TW + SCALE_W + 1 - ELU_FRAC;
   localparam int YW        = ((DATA_WIDTH > EW) ? DATA_WIDTH : EW) + 1;

   localparam int FUNC_W    = 3;
   localparam logic [FUNC_W-1:0] FUNC_SIGMOID = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_TANH    = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_RELU    = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_LEAKY   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_ELU     = 3'd4;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEAKY_SLOPE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ELU_SCALE   = 1'd1;
   localparam int CSR_DATA_W = 16;

   localparam logic [SLOPE_W-1:0] LEAKY_SLOPE_RESET = 16'd66;
   localparam logic [SCALE_W-1:0] ELU_SCALE_RESET   = 15'd4096;

   localparam int KIND_SIG  = 0;
   localparam int KIND_TANH = 1;
   localparam int KIND_EXP  = 2;

   typedef logic [TABLE_ENTRIES:0][TW-1:0] tab_type;

   typedef struct packed {
      logic [TW-1:0] base;   // entry at the lower sample
      logic [TW-1:0] step;   // distance to the upper sample
      logic          down;   // upper sample lies below the lower one
   } lut_read_type;

   // Shift-subtract division, elaboration only.
   function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] q;
      logic [63:0] r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[62:0], n[i]};
         if (r >= d) begin
            r = r - d;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // exp(-t), argument and result in Q30.
   function automatic logic [63:0] exp_neg_q30(input logic [63:0] t);
      logic [63:0] n;
      logic [63:0] f;
      logic [63:0] pos;
      logic [63:0] neg;
      logic [63:0] term;
      logic [63:0] r;
      n    = t >> 30;
      f    = t & ((64'd1 << 30) - 64'd1);
      pos  = 64'd1 << 30;
      neg  = '0;
      term = 64'd1 << 30;
      for (int k = 1; k <= 24; k++) begin
         term = udiv((term * f) >> 30, 64'(k));
         if ((k % 2) == 1) neg = neg + term;
         else              pos = pos + term;
      end
      r = (pos > neg) ? pos - neg : 64'd0;
      if (n > 64'd40) return 64'd0;
      for (int k = 0; k < 40; k++) begin
         if (64'(k) < n) r = (r * 64'd395007542) >> 30;
      end
      return r;
   endfunction

   function automatic tab_type build_tab(input int kind);
      tab_type     tab;
      logic [63:0] t;
      logic [63:0] e;
      logic [63:0] e2;
      logic [63:0] den;
      logic [63:0] den2;
      logic [63:0] diff2;
      logic [63:0] v;
      tab = '0;
      for (int i = 0; i <= TABLE_ENTRIES; i++) begin
         t     = udiv(64'(i) << (30 + SPAN_LOG2), 64'(TABLE_ENTRIES));
         e     = exp_neg_q30(t);
         e2    = exp_neg_q30(t << 1);
         den   = (64'd1 << 30) + e;
         den2  = (64'd1 << 30) + e2;
         diff2 = ((64'd1 << 30) > e2) ? (64'd1 << 30) - e2 : 64'd0;
         if (kind == KIND_SIG)
            v = udiv((64'd1 << (FRAC_BITS + 30)) + (den >> 1), den);
         else if (kind == KIND_TANH)
            v = udiv((diff2 << FRAC_BITS) + (den2 >> 1), den2);
         else
            v = ((e << FRAC_BITS) + (64'd1 << 29)) >> 30;
         tab[i] = v[TW-1:0];
      end
      return tab;
   endfunction

endpackage

### sv/afu_lookup.sv
// Table read: picks the function's table and fetches the two samples around a position.
`timescale 1ns / 1ps

module afu_lookup
   import afu_pkg::*;
(
   input  logic [FUNC_W-1:0] func,
   input  logic [IDX_W-1:0]  idx_lo,
   input  logic [IDX_W-1:0]  idx_hi,
   output lut_read_type      rd
);

   localparam tab_type SIG_TAB  = build_tab(KIND_SIG);
   localparam tab_type TANH_TAB = build_tab(KIND_TANH);
   localparam tab_type EXP_TAB  = build_tab(KIND_EXP);

   logic [TW-1:0] lo;
   logic [TW-1:0] hi;

   always_comb begin
      unique case (func)
         FUNC_SIGMOID: begin
            lo = SIG_TAB[idx_lo];
            hi = SIG_TAB[idx_hi];
         end
         FUNC_TANH: begin
            lo = TANH_TAB[idx_lo];
            hi = TANH_TAB[idx_hi];
         end
         default: begin
            lo = EXP_TAB[idx_lo];
            hi = EXP_TAB[idx_hi];
         end
      endcase
   end

   always_comb begin
      rd.base = lo;
      rd.down = hi < lo;
      rd.step = rd.down ? lo - hi : hi - lo;
   end

endmodule

### sv/activation_function_unit.sv
// Activation function unit top level: five-stage elementwise activation pipeline.
`timescale 1ns / 1ps
//
// Usage
//   req_*  : one Q4.12 element per transaction with a function code and a last flag.
//            A transaction completes on a clock edge with req_valid high and req_stall low.
//   rsp_*  : the activated element, saturated to Q4.12, and the copied last flag.
//   csr_*  : register writes (index 0 leaky slope Q0.16, index 1 ELU alpha Q3.12).
//            csr_ready is always high; write only while the pipeline is empty.
//   Path    : result reaches rsp_* through five register stages, the first loaded at
//             the accepting edge.
//   Rate    : one transaction per cycle while rsp_stall is low; every stage is a single register slot.
//   Stages  : 1 magnitude and table position, 2 table read, 3 interpolation and
//             leaky product, 4 ELU product, 5 output register (select, saturate).
//   Stall   : each stage advances when its successor is empty or moving, so bubbles
//             close up; a full pipeline behind a stalled rsp holds req_stall high
//             and nothing is lost or repeated.
//   Reset   : synchronous; clears the valid bits and reloads both registers
//             (slope 66, alpha 4096). Tables are constants.
//
module activation_function_unit
   import afu_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [DATA_WIDTH-1:0] req_value,
   input  logic [FUNC_W-1:0]            req_func,
   input  logic                         req_last,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0] rsp_result,
   output logic                         rsp_result_last,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata
);

   localparam logic signed [YW-1:0] SAT_HI = YW'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
   localparam logic signed [YW-1:0] SAT_LO = -SAT_HI - YW'(1);
   localparam logic [TW-1:0]        ONE    = TW'(64'd1 << FRAC_BITS);

   // ---------------- configuration registers ----------------
   logic [SLOPE_W-1:0] slope_ff;
   logic [SCALE_W-1:0] scale_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         slope_ff <= LEAKY_SLOPE_RESET;
         scale_ff <= ELU_SCALE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LEAKY_SLOPE: slope_ff <= csr_wdata[SLOPE_W-1:0];
            CSR_ELU_SCALE:   scale_ff <= csr_wdata[SCALE_W-1:0];
         endcase
      end
   end

   // ---------------- flow control ----------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, rsp_valid_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;

   assign rdy5 = !rsp_valid_ff || !rsp_stall;
   assign rdy4 = !s4_valid_ff  || rdy5;
   assign rdy3 = !s3_valid_ff  || rdy4;
   assign rdy2 = !s2_valid_ff  || rdy3;
   assign rdy1 = !s1_valid_ff  || rdy2;
   assign req_stall = !rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rdy1) s1_valid_ff  <= req_valid;
         if (rdy2) s2_valid_ff  <= s1_valid_ff;
         if (rdy3) s3_valid_ff  <= s2_valid_ff;
         if (rdy4) s4_valid_ff  <= s3_valid_ff;
         if (rdy5) rsp_valid_ff <= s4_valid_ff;
      end
   end

   // ---------------- stage 1: magnitude and table position ----------------
   logic                  neg_in, pos_in, beyond;
   logic [MAG_W-1:0]      mag_in;
   logic [PW-1:0]         pos_prod, pos_shift;
   logic [IDX_W-1:0]      idx_lo_in, idx_hi_in;
   logic [SH-1:0]         rem_in;

   always_comb begin
      neg_in    = req_value[DATA_WIDTH-1];
      pos_in    = !neg_in && (req_value != '0);
      mag_in    = neg_in ? (~req_value + MAG_W'(1)) : req_value;
      pos_prod  = PW'(mag_in) * PW'(TABLE_ENTRIES);
      pos_shift = pos_prod >> SH;
      beyond    = pos_shift >= PW'(TABLE_ENTRIES);
      idx_lo_in = beyond ? IDX_W'(TABLE_ENTRIES) : pos_shift[IDX_W-1:0];
      idx_hi_in = beyond ? IDX_W'(TABLE_ENTRIES) : pos_shift[IDX_W-1:0] + IDX_W'(1);
      rem_in    = beyond ? '0 : pos_prod[SH-1:0];
   end

   logic signed [DATA_WIDTH-1:0] s1_value_ff;
   logic [FUNC_W-1:0]            s1_func_ff;
   logic                         s1_last_ff, s1_neg_ff, s1_pos_ff;
   logic [MAG_W-1:0]             s1_mag_ff;
   logic [IDX_W-1:0]             s1_idx_lo_ff, s1_idx_hi_ff;
   logic [SH-1:0]                s1_rem_ff;

   always_ff @(posedge clock) begin
      if (rdy1 && req_valid) begin
         s1_value_ff  <= req_value;
         s1_func_ff   <= req_func;
         s1_last_ff   <= req_last;
         s1_neg_ff    <= neg_in;
         s1_pos_ff    <= pos_in;
         s1_mag_ff    <= mag_in;
         s1_idx_lo_ff <= idx_lo_in;
         s1_idx_hi_ff <= idx_hi_in;
         s1_rem_ff    <= rem_in;
      end
   end

   // ---------------- stage 2: table read ----------------
   lut_read_type rd_in;

   afu_lookup u_lookup (
      .func   (s1_func_ff),
      .idx_lo (s1_idx_lo_ff),
      .idx_hi (s1_idx_hi_ff),
      .rd     (rd_in)
   );

   logic signed [DATA_WIDTH-1:0] s2_value_ff;
   logic [FUNC_W-1:0]            s2_func_ff;
   logic                         s2_last_ff, s2_neg_ff, s2_pos_ff;
   logic [MAG_W-1:0]             s2_mag_ff;
   logic [SH-1:0]                s2_rem_ff;
   lut_read_type                 s2_rd_ff;

   always_ff @(posedge clock) begin
      if (rdy2 && s1_valid_ff) begin
         s2_value_ff <= s1_value_ff;
         s2_func_ff  <= s1_func_ff;
         s2_last_ff  <= s1_last_ff;
         s2_neg_ff   <= s1_neg_ff;
         s2_pos_ff   <= s1_pos_ff;
         s2_mag_ff   <= s1_mag_ff;
         s2_rem_ff   <= s1_rem_ff;
         s2_rd_ff    <= rd_in;
      end
   end

   // ---------------- stage 3: interpolation, leaky product ----------------
   logic [TW+SH-1:0]        step_prod;
   logic [TW-1:0]           lut_in;
   logic [MAG_W+SLOPE_W:0]  leaky_sum;
   logic [MAG_W-1:0]        leaky_in;

   always_comb begin
      // step toward the upper sample, truncated toward the lower one
      step_prod = (TW+SH)'(s2_rd_ff.step) * (TW+SH)'(s2_rem_ff);
      lut_in    = s2_rd_ff.down ? s2_rd_ff.base - step_prod[TW+SH-1:SH]
                                : s2_rd_ff.base + step_prod[TW+SH-1:SH];
      // ceiling of |x| * slope keeps the negative branch rounded toward minus infinity
      leaky_sum = (MAG_W+SLOPE_W+1)'(s2_mag_ff) * (MAG_W+SLOPE_W+1)'(slope_ff)
                + (MAG_W+SLOPE_W+1)'({SLOPE_W{1'b1}});
      leaky_in  = leaky_sum[MAG_W+SLOPE_W-1:SLOPE_W];
   end

   logic signed [DATA_WIDTH-1:0] s3_value_ff;
   logic [FUNC_W-1:0]            s3_func_ff;
   logic                         s3_last_ff, s3_neg_ff, s3_pos_ff;
   logic [TW-1:0]                s3_lut_ff;
   logic [MAG_W-1:0]             s3_leaky_ff;

   always_ff @(posedge clock) begin
      if (rdy3 && s2_valid_ff) begin
         s3_value_ff <= s2_value_ff;
         s3_func_ff  <= s2_func_ff;
         s3_last_ff  <= s2_last_ff;
         s3_neg_ff   <= s2_neg_ff;
         s3_pos_ff   <= s2_pos_ff;
         s3_lut_ff   <= lut_in;
         s3_leaky_ff <= leaky_in;
      end
   end

   // ---------------- stage 4: ELU product ----------------
   logic [TW-1:0]         em1;
   logic [TW+SCALE_W:0]   elu_sum;
   logic [EW-1:0]         elu_in;

   always_comb begin
      em1     = (ONE > s3_lut_ff) ? ONE - s3_lut_ff : '0;
      elu_sum = (TW+SCALE_W+1)'(em1) * (TW+SCALE_W+1)'(scale_ff)
              + (TW+SCALE_W+1)'((64'd1 << ELU_FRAC) - 64'd1);
      elu_in  = elu_sum[TW+SCALE_W:ELU_FRAC];
   end

   logic signed [DATA_WIDTH-1:0] s4_value_ff;
   logic [FUNC_W-1:0]            s4_func_ff;
   logic                         s4_last_ff, s4_neg_ff, s4_pos_ff;
   logic [TW-1:0]                s4_lut_ff;
   logic [MAG_W-1:0]             s4_leaky_ff;
   logic [EW-1:0]                s4_elu_ff;

   always_ff @(posedge clock) begin
      if (rdy4 && s3_valid_ff) begin
         s4_value_ff <= s3_value_ff;
         s4_func_ff  <= s3_func_ff;
         s4_last_ff  <= s3_last_ff;
         s4_neg_ff   <= s3_neg_ff;
         s4_pos_ff   <= s3_pos_ff;
         s4_lut_ff   <= s3_lut_ff;
         s4_leaky_ff <= s3_leaky_ff;
         s4_elu_ff   <= elu_in;
      end
   end

   // ---------------- stage 5: select and saturate ----------------
   logic signed [YW-1:0]         x_ext, lut_ext, y;
   logic signed [DATA_WIDTH-1:0] rsp_result_in;

   always_comb begin
      x_ext   = YW'(s4_value_ff);
      lut_ext = signed'(YW'(s4_lut_ff));
      unique case (s4_func_ff)
         FUNC_SIGMOID: y = s4_neg_ff ? signed'(YW'(ONE)) - lut_ext : lut_ext;
         FUNC_TANH:    y = s4_neg_ff ? -lut_ext : lut_ext;
         FUNC_RELU:    y = s4_pos_ff ? x_ext : '0;
         FUNC_LEAKY:   y = s4_pos_ff ? x_ext : -signed'(YW'(s4_leaky_ff));
         FUNC_ELU:     y = s4_pos_ff ? x_ext : -signed'(YW'(s4_elu_ff));
         default:      y = x_ext;   // pass-through codes
      endcase
      if (y > SAT_HI)      rsp_result_in = SAT_HI[DATA_WIDTH-1:0];
      else if (y < SAT_LO) rsp_result_in = SAT_LO[DATA_WIDTH-1:0];
      else                 rsp_result_in = y[DATA_WIDTH-1:0];
   end

   logic signed [DATA_WIDTH-1:0] rsp_result_ff;
   logic                         rsp_last_ff;

   always_ff @(posedge clock) begin
      if (rdy5 && s4_valid_ff) begin
         rsp_result_ff <= rsp_result_in;
         rsp_last_ff   <= s4_last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result      = rsp_result_ff;
   assign rsp_result_last = rsp_last_ff;

   // ---------------- assertions ----------------
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> s1_valid_ff)
      else $error("accepted transaction did not enter stage 1");

   a_full_holds_off: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_valid_ff && s3_valid_ff && s4_valid_ff && rsp_valid_ff
       && rsp_stall) |-> req_stall)
      else $error("full pipeline accepted a transaction under stall");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> (!s1_valid_ff && !s4_valid_ff && !rsp_valid_ff))
      else $error("pipeline not empty after reset");

   a_stall_keeps_stage4: assert property (@(posedge clock) disable iff (reset)
      (s4_valid_ff && rsp_valid_ff && rsp_stall) |=> s4_valid_ff)
      else $error("stage 4 dropped a transaction under stall");

endmodule
